[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked assertion helpers; all are sampled on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the condition, outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[hw/rtl/lmbb_pkg.sv]
// ----------------------------------------------------------------------------
// lmbb_pkg
// Types, constants and helpers for the label mask / bounding box block.
// ----------------------------------------------------------------------------
package lmbb_pkg;

  localparam int COORD_BITS    = 10;
  localparam int LABEL_BITS    = 16;
  localparam int INTEN_BITS    = 32;
  localparam int NUM_AXES      = 3;
  localparam int DIM_BITS      = COORD_BITS + 1;
  localparam int CFG_DATA_BITS = (LABEL_BITS > DIM_BITS) ? LABEL_BITS : DIM_BITS;
  localparam int CFG_IDX_BITS  = 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [INTEN_BITS-1:0] inten_t;

  localparam dim_t   DIM_MAX   = dim_t'(1) << COORD_BITS;
  localparam coord_t COORD_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TARGET_LABEL    = 3'd0,
    REG_ZERO_BACKGROUND = 3'd1,
    REG_BOUNDARY_SIZE   = 3'd2,
    REG_DIM_X           = 3'd3,
    REG_DIM_Y           = 3'd4,
    REG_DIM_Z           = 3'd5
  } cfg_index_t;

  typedef struct packed {
    label_t                      target_label;
    logic                        zero_background;
    coord_t                      boundary_size;
    dim_t   [NUM_AXES-1:0]       dim;
  } cfg_t;

  typedef struct packed {
    coord_t [NUM_AXES-1:0] lo;
    coord_t [NUM_AXES-1:0] hi;
  } box_t;

  // Highest valid index along an axis; extent 0 reads as 1, above max as max.
  function automatic coord_t last_index(dim_t d);
    coord_t r;
    if (d == '0) begin
      r = '0;
    end else if (d > DIM_MAX) begin
      r = COORD_MAX;
    end else begin
      r = coord_t'(d - dim_t'(1));
    end
    return r;
  endfunction

  function automatic coord_t widen_low(coord_t v, coord_t b);
    return (v > b) ? coord_t'(v - b) : '0;
  endfunction

  function automatic coord_t widen_high(coord_t v, coord_t b, coord_t top);
    dim_t w;
    w = dim_t'(v) + dim_t'(b);
    return (w < dim_t'(top)) ? coord_t'(w) : top;
  endfunction

endpackage

[hw/rtl/lmbb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lmbb_cfg_regs
// Write-only configuration register file.
// ----------------------------------------------------------------------------
module lmbb_cfg_regs
  import lmbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_label    <= label_t'(1);
      cfg.zero_background <= 1'b0;
      cfg.boundary_size   <= coord_t'(1);
      for (int i = 0; i < NUM_AXES; i++) begin
        cfg.dim[i] <= DIM_MAX;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_TARGET_LABEL:    cfg.target_label    <= wr_data[LABEL_BITS-1:0];
        REG_ZERO_BACKGROUND: cfg.zero_background <= wr_data[0];
        REG_BOUNDARY_SIZE:   cfg.boundary_size   <= wr_data[COORD_BITS-1:0];
        REG_DIM_X:           cfg.dim[0]          <= wr_data[DIM_BITS-1:0];
        REG_DIM_Y:           cfg.dim[1]          <= wr_data[DIM_BITS-1:0];
        REG_DIM_Z:           cfg.dim[2]          <= wr_data[DIM_BITS-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

[hw/rtl/lmbb_box_unit.sv]
// ----------------------------------------------------------------------------
// lmbb_box_unit
// Running min/max box per axis, plus the widened, clamped box for emission.
// ----------------------------------------------------------------------------
module lmbb_box_unit
  import lmbb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   advance,   // item moves to the result register
  input  logic                   hit,       // kept label is nonzero
  input  logic                   last,
  input  coord_t [NUM_AXES-1:0]  pos,
  output box_t                   emit_box
);

  coord_t [NUM_AXES-1:0] run_min;
  coord_t [NUM_AXES-1:0] run_max;
  coord_t [NUM_AXES-1:0] run_min_next;
  coord_t [NUM_AXES-1:0] run_max_next;
  coord_t [NUM_AXES-1:0] top;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      top[i]          = last_index(cfg.dim[i]);
      run_min_next[i] = (hit && (pos[i] < run_min[i])) ? pos[i] : run_min[i];
      run_max_next[i] = (hit && (pos[i] > run_max[i])) ? pos[i] : run_max[i];
      emit_box.lo[i]  = widen_low(run_min_next[i], cfg.boundary_size);
      emit_box.hi[i]  = widen_high(run_max_next[i], cfg.boundary_size, top[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        run_min[i] <= COORD_MAX;
        run_max[i] <= '0;
      end
    end else if (advance) begin
      if (last) begin
        run_min <= top;
        run_max <= '0;
      end else begin
        run_min <= run_min_next;
        run_max <= run_max_next;
      end
    end
  end

endmodule

[hw/rtl/label_mask_bounding_box_top.sv]
// ----------------------------------------------------------------------------
// label_mask_bounding_box_top
// Masks a streamed 3D label volume to one target label and reports the
// margin-widened bounding box of the kept voxels on the last voxel.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_stall  | pos_x/y/z, voxel_label, voxel_intensity,
//           |                    | last_voxel
//  out      | out_valid/out_stall| out_label, out_intensity, box_valid,
//           |                    | box_min_x/y/z, box_max_x/y/z
//  cfg      | wr_en              | wr_index, wr_data
//
//  One request per cycle sustained while out_stall is low; an accepted
//  request is held in the input register and then moves into the result
//  register, where out_valid rises. The rate is set by the input-register to
//  result-register path (label compare, min/max update, then widen and clamp).
//  Synchronous active-high rst resets control state, the running box and the
//  config registers to their defaults; no clearing pass is needed.
//  in_stall rises only when the input register is full and the result
//  register is held by out_stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module label_mask_bounding_box_top
  import lmbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  // input voxel stream
  input  logic                     in_valid,
  output logic                     in_stall,
  input  coord_t                   pos_x,
  input  coord_t                   pos_y,
  input  coord_t                   pos_z,
  input  label_t                   voxel_label,
  input  inten_t                   voxel_intensity,
  input  logic                     last_voxel,
  // result stream
  output logic                     out_valid,
  input  logic                     out_stall,
  output label_t                   out_label,
  output inten_t                   out_intensity,
  output logic                     box_valid,
  output coord_t                   box_min_x,
  output coord_t                   box_min_y,
  output coord_t                   box_min_z,
  output coord_t                   box_max_x,
  output coord_t                   box_max_y,
  output coord_t                   box_max_z
);

  cfg_t cfg;

  // Input register (stage 1)
  logic                  s1_valid;
  coord_t [NUM_AXES-1:0] s1_pos;
  label_t                s1_label;
  inten_t                s1_intensity;
  logic                  s1_last;

  // Handshake
  logic in_acc;
  logic out_ready;   // result register can take a new request this cycle
  logic advance;     // stage 1 moves into the result register

  // Masking
  logic   keep;
  label_t mask_label;
  inten_t mask_intensity;
  logic   hit;
  box_t   emit_box;

  lmbb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos       <= {pos_z, pos_y, pos_x};
      s1_label     <= voxel_label;
      s1_intensity <= voxel_intensity;
      s1_last      <= last_voxel;
    end
  end

  // Keep the target label, zero everything else; intensity follows policy.
  assign keep           = (s1_label == cfg.target_label);
  assign mask_label     = keep ? s1_label : '0;
  assign mask_intensity = (!keep && cfg.zero_background) ? '0 : s1_intensity;
  assign hit            = (mask_label != '0);

  lmbb_box_unit u_box (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .advance  (advance),
    .hit      (hit),
    .last     (s1_last),
    .pos      (s1_pos),
    .emit_box (emit_box)
  );

  // Result register (stage 2)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_label     <= mask_label;
      out_intensity <= mask_intensity;
      box_valid     <= s1_last;
      // box fields read zero except on the last voxel
      box_min_x     <= s1_last ? emit_box.lo[0] : '0;
      box_min_y     <= s1_last ? emit_box.lo[1] : '0;
      box_min_z     <= s1_last ? emit_box.lo[2] : '0;
      box_max_x     <= s1_last ? emit_box.hi[0] : '0;
      box_max_y     <= s1_last ? emit_box.hi[1] : '0;
      box_max_z     <= s1_last ? emit_box.hi[2] : '0;
    end
  end

  // Back-pressure only arises with a held request in the input register.
  `ASSERT_CLK(a_stall_needs_s1, !in_stall || s1_valid, "in_stall with empty input register")
  // A request moved out of stage 1 shows up as a result next cycle.
  `ASSERT_NEXT(a_advance_to_out, advance, out_valid, "advanced request lost")
  // Non-last results carry an all-zero box.
  `ASSERT_CLK(a_box_zero, !out_valid || box_valid || (box_max_x == '0), "box on non-last result")

endmodule

[sim/lmbb_box_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbb_box_checker
// Watches the config port and both streams of the label mask / bounding box
// block. It predicts each result from the accepted request and compares it.
// ----------------------------------------------------------------------------
module lmbb_box_checker
  import lmbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  coord_t                   pos_x,
  input  coord_t                   pos_y,
  input  coord_t                   pos_z,
  input  label_t                   voxel_label,
  input  inten_t                   voxel_intensity,
  input  logic                     last_voxel,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  label_t                   out_label,
  input  inten_t                   out_intensity,
  input  logic                     box_valid,
  input  coord_t                   box_min_x,
  input  coord_t                   box_min_y,
  input  coord_t                   box_min_z,
  input  coord_t                   box_max_x,
  input  coord_t                   box_max_y,
  input  coord_t                   box_max_z,
  output int                       mismatches,
  output int                       outstanding
);

  typedef struct packed {
    label_t label;
    inten_t intensity;
    logic   box_valid;
    box_t   box;
  } voxel_out_t;

  // shadow registers and running box; axis 0 is x, 2 is z
  label_t                    tgt_label;
  logic                      zero_bg;
  coord_t                    margin;
  dim_t   [NUM_AXES-1:0]     extent;
  coord_t [NUM_AXES-1:0]     run_lo;
  coord_t [NUM_AXES-1:0]     run_hi;

  voxel_out_t expected_voxels[$];
  int         errors = 0;

  assign mismatches = errors;

  // last usable index of an axis; 0 behaves as 1, oversize as the maximum
  function automatic coord_t axis_top(dim_t d);
    int e;
    e = int'(d);
    if (e < 1) e = 1;
    if (e > int'(DIM_MAX)) e = int'(DIM_MAX);
    return coord_t'(e - 1);
  endfunction

  function automatic void restart_box();
    for (int a = 0; a < NUM_AXES; a++) begin
      run_lo[a] = axis_top(extent[a]);
      run_hi[a] = '0;
    end
  endfunction

  function automatic voxel_out_t mask_and_track(coord_t [NUM_AXES-1:0] pos, label_t lab,
                                                inten_t inten, logic last);
    voxel_out_t r;
    logic       hit;
    int         wide;
    coord_t     top;
    r = '0;
    hit = (lab == tgt_label);
    r.label = hit ? lab : '0;
    r.intensity = (!hit && zero_bg) ? '0 : inten;
    if (r.label != '0) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (pos[a] < run_lo[a]) run_lo[a] = pos[a];
        if (pos[a] > run_hi[a]) run_hi[a] = pos[a];
      end
    end
    if (last) begin
      r.box_valid = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        r.box.lo[a] = (run_lo[a] > margin) ? coord_t'(run_lo[a] - margin) : '0;
        top = axis_top(extent[a]);
        wide = int'(run_hi[a]) + int'(margin);
        r.box.hi[a] = (wide < int'(top)) ? coord_t'(wide) : top;
      end
      restart_box();
    end
    return r;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t lmbb_box_checker: %s expected 0x%0h, got 0x%0h",
               $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    voxel_out_t want;
    voxel_out_t got;
    string      lo_name [NUM_AXES];
    string      hi_name [NUM_AXES];
    lo_name = '{"box_min_x", "box_min_y", "box_min_z"};
    hi_name = '{"box_max_x", "box_max_y", "box_max_z"};
    if (rst) begin
      tgt_label = label_t'(1);
      zero_bg   = 1'b0;
      margin    = coord_t'(1);
      for (int a = 0; a < NUM_AXES; a++) extent[a] = DIM_MAX;
      restart_box();
      expected_voxels.delete();
    end else begin
      if (wr_en) begin
        case (cfg_index_t'(wr_index))
          REG_TARGET_LABEL:    tgt_label = label_t'(wr_data);
          REG_ZERO_BACKGROUND: zero_bg   = wr_data[0];
          REG_BOUNDARY_SIZE:   margin    = coord_t'(wr_data);
          REG_DIM_X:           extent[0] = dim_t'(wr_data);
          REG_DIM_Y:           extent[1] = dim_t'(wr_data);
          REG_DIM_Z:           extent[2] = dim_t'(wr_data);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.label     = out_label;
        got.intensity = out_intensity;
        got.box_valid = box_valid;
        got.box.lo    = {box_min_z, box_min_y, box_min_x};
        got.box.hi    = {box_max_z, box_max_y, box_max_x};
        if (expected_voxels.size() == 0) begin
          errors++;
          $display("%0t lmbb_box_checker: result expected none, got label 0x%0h",
                   $time, out_label);
        end else begin
          want = expected_voxels.pop_front();
          check_field("out_label", want.label, got.label);
          check_field("out_intensity", want.intensity, got.intensity);
          check_field("box_valid", want.box_valid, got.box_valid);
          for (int a = 0; a < NUM_AXES; a++) begin
            check_field(lo_name[a], want.box.lo[a], got.box.lo[a]);
            check_field(hi_name[a], want.box.hi[a], got.box.hi[a]);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_voxels.insert(expected_voxels.size(),
                               mask_and_track({pos_z, pos_y, pos_x}, voxel_label,
                                              voxel_intensity, last_voxel));
    end
    outstanding <= expected_voxels.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives label_mask_bounding_box_top with directed voxels and random volumes
// under a range of register settings and back-pressure; lmbb_box_checker
// predicts every result and counts mismatches for the verdict here.
// ----------------------------------------------------------------------------
module tb;
  import lmbb_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  wr_index = '0;
  logic [CFG_DATA_BITS-1:0] wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  coord_t                   pos_x = '0;
  coord_t                   pos_y = '0;
  coord_t                   pos_z = '0;
  label_t                   voxel_label = '0;
  inten_t                   voxel_intensity = '0;
  logic                     last_voxel = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  label_t                   out_label;
  inten_t                   out_intensity;
  logic                     box_valid;
  coord_t                   box_min_x, box_min_y, box_min_z;
  coord_t                   box_max_x, box_max_y, box_max_z;

  int mismatches;
  int outstanding;

  // idle rates in percent for each side
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // one long receiver hold-off, owned by the receiver process once armed
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int sent = 0;   // accepted requests

  // current register values as the stimulus sees them (axis 0 is x)
  label_t                cur_target = label_t'(1);
  dim_t [NUM_AXES-1:0]   cur_extent = {NUM_AXES{DIM_MAX}};

  always #10 clk = ~clk;

  label_mask_bounding_box_top dut (.*);

  lmbb_box_checker chk (.*);

  // Receiver: random stalls, or one solid hold-off once armed.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 150;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offer one voxel request, with random idle cycles in front of it, and
  // hold it steady until the block takes it.
  task automatic push_voxel(coord_t x, coord_t y, coord_t z, label_t lab, inten_t inten,
                            logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    pos_x           <= x;
    pos_y           <= y;
    pos_z           <= z;
    voxel_label     <= lab;
    voxel_intensity <= inten;
    last_voxel      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Stop offering, let every predicted result come out, then cover the
  // pipeline with a little slack.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(label_t tl, logic zb, coord_t bnd, dim_t dx, dim_t dy, dim_t dz);
    wait_idle();
    write_reg(REG_TARGET_LABEL, tl);
    write_reg(REG_ZERO_BACKGROUND, CFG_DATA_BITS'(zb));
    write_reg(REG_BOUNDARY_SIZE, CFG_DATA_BITS'(bnd));
    write_reg(REG_DIM_X, CFG_DATA_BITS'(dx));
    write_reg(REG_DIM_Y, CFG_DATA_BITS'(dy));
    write_reg(REG_DIM_Z, CFG_DATA_BITS'(dz));
    // all-ones index maps to no register; the write must be dropped
    write_reg('1, CFG_DATA_BITS'($urandom));
    cur_target = tl;
    cur_extent = {dz, dy, dx};
  endtask

  // Extents lean small so whole rasters fit; extremes and out-of-range
  // values (0 and above 1024) still show up.
  function automatic dim_t pick_extent();
    case ($urandom_range(0, 11))
      0:       return dim_t'(1);
      1:       return DIM_MAX;
      2:       return '0;
      3:       return dim_t'($urandom_range(1025, 2047));
      4:       return dim_t'($urandom_range(1, 1024));
      default: return dim_t'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_config();
    label_t tl;
    coord_t bnd;
    case ($urandom_range(0, 5))
      0:       tl = '0;
      1:       tl = '1;
      2:       tl = label_t'(1);
      default: tl = label_t'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       bnd = '0;
      1:       bnd = '1;
      2:       bnd = coord_t'($urandom_range(1, 4));
      default: bnd = coord_t'($urandom);
    endcase
    configure(tl, 1'($urandom_range(0, 1)), bnd, pick_extent(), pick_extent(),
              pick_extent());
  endtask

  // Mostly the target label, then exterior, then anything.
  function automatic label_t pick_label();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return cur_target;
    if (r < 14) return '0;
    return label_t'($urandom);
  endfunction

  // Inside the extent, now and then anywhere in the coordinate range.
  function automatic coord_t pick_coord(int ext);
    if ($urandom_range(0, 19) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, ext - 1));
  endfunction

  // One well-formed volume: a full raster when it is small, else a sparse
  // scatter of voxels; the final request carries last_voxel.
  task automatic push_volume();
    int ext [NUM_AXES];
    int n;
    for (int a = 0; a < NUM_AXES; a++) begin
      ext[a] = int'(cur_extent[a]);
      if (ext[a] < 1) ext[a] = 1;
      if (ext[a] > int'(DIM_MAX)) ext[a] = int'(DIM_MAX);
    end
    if (ext[0] * ext[1] * ext[2] <= 64) begin
      for (int z = 0; z < ext[2]; z++)
        for (int y = 0; y < ext[1]; y++)
          for (int x = 0; x < ext[0]; x++)
            push_voxel(coord_t'(x), coord_t'(y), coord_t'(z), pick_label(), $urandom,
                       x == ext[0] - 1 && y == ext[1] - 1 && z == ext[2] - 1);
    end else begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++)
        push_voxel(pick_coord(ext[0]), pick_coord(ext[1]), pick_coord(ext[2]),
                   pick_label(), $urandom, i == n - 1);
    end
  endtask

  // Broken runs: arbitrary fields, last_voxel at random.
  task automatic push_noise();
    int n;
    n = $urandom_range(1, 5);
    repeat (n)
      push_voxel(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 label_t'($urandom), $urandom, $urandom_range(0, 3) == 0);
  endtask

  // One idling mode: random settings, each followed by a batch of volumes.
  // With squeeze set the receiver hold-off is armed so the block backs up.
  task automatic run_mode(int send_pct, int recv_pct, int n_items, logic squeeze);
    int stop;
    int chunk;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    stop = sent + n_items;
    while (sent < stop) begin
      random_config();
      if (squeeze) begin
        hold_arm <= 1'b1;
        squeeze = 1'b0;
      end
      chunk = sent + $urandom_range(60, 160);
      if (chunk > stop) chunk = stop;
      while (sent < chunk) begin
        if ($urandom_range(0, 99) < 8) push_noise();
        else push_volume();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst            <= 1'b0;
    send_idle_pct  <= 11;
    recv_stall_pct <= 75;
    @(posedge clk);

    // --- directed, registers at reset values (target 1, margin 1, 1024^3)
    // empty volume: degenerate box
    push_voxel('0, '0, '0, '0, '0, 1'b1);
    // box spanning the whole coordinate range, clamp at the top
    push_voxel('0, '0, '0, label_t'(1), '0, 1'b0);
    push_voxel('1, '1, '1, label_t'(1), '1, 1'b0);
    push_voxel(5, 6, 7, '1, 32'hA5A5_5A5A, 1'b0);
    push_voxel(512, 512, 512, '0, 32'h1234_5678, 1'b1);
    // single kept voxel widened by the margin
    push_voxel(1, 1, 1, label_t'(1), 32'h0F0F_F0F0, 1'b0);
    push_voxel(2, 2, 2, label_t'(3), 32'h8000_0001, 1'b1);

    // target label 0 with background zeroing, 1-voxel volume
    configure('0, 1'b1, '0, dim_t'(1), dim_t'(1), dim_t'(1));
    push_voxel('0, '0, '0, '0, 32'hDEAD_BEEF, 1'b0);
    push_voxel('0, '0, '0, label_t'(1), '1, 1'b0);
    push_voxel('1, '0, '1, '1, 32'h0000_0007, 1'b0);
    push_voxel('0, '0, '0, '0, '1, 1'b1);

    // extents out of range, widest margin, coordinate beyond the z extent
    configure('1, 1'b1, '1, '0, dim_t'(2047), dim_t'(5));
    push_voxel(3, 4, 1000, '1, 32'h5555_AAAA, 1'b0);
    push_voxel(9, 9, 9, label_t'(16'h7FFF), 32'hFFFF_0000, 1'b0);
    push_voxel('0, '0, '0, '1, 32'h0000_0001, 1'b1);

    // x extent shrinks while a volume is open
    configure(label_t'(7), 1'b0, coord_t'(2), dim_t'(16), dim_t'(16), dim_t'(16));
    push_voxel(10, 10, 10, label_t'(7), $urandom, 1'b0);
    wait_idle();
    write_reg(REG_DIM_X, CFG_DATA_BITS'(dim_t'(8)));
    cur_extent[0] = dim_t'(8);
    push_voxel(12, 3, 4, label_t'(7), $urandom, 1'b1);
    // next box starts from the new extent
    push_voxel('0, '0, '0, '0, $urandom, 1'b1);

    // --- random volumes: sender rarely idle, then receiver rarely stalls,
    // then flat out with one long receiver hold-off
    run_mode(11, 75, 560, 1'b0);
    run_mode(75, 11, 560, 1'b0);
    run_mode(0, 0, 560, 1'b1);

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
